>>> hdl/udpdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpdm_pkg: shared types and constants of the udp port demux
// item layouts, outcome codes, slot table command and record types
// ----------------------------------------------------------------------------
package udpdm_pkg;

  // default sizing
  localparam int LINK_COUNT_DEF     = 4;
  localparam int SLOTS_PER_LINK_DEF = 8;

  // fixed field widths
  localparam int PORT_W    = 16;
  localparam int IP_W      = 32;
  localparam int LEN_W     = 16;
  localparam int LINK_IDX_W = 2;
  localparam int SLOT_FLD_W = 3;
  localparam int BUF_W     = 3;
  localparam int OUTC_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_REGS  = 4;
  // widest slot number over the supported range (up to 64 slots a link)
  localparam int SLOT_CMD_W = 6;

  // request kinds
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUT_UNREACHABLE = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_NO_SLOT     = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_ACCEPTED    = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_RELEASED    = 2'd3;

  typedef struct packed {
    logic                  req_type;
    logic [PORT_W-1:0]     dest_port;
    logic [PORT_W-1:0]     src_port;
    logic [IP_W-1:0]       src_ip;
    logic [LEN_W-1:0]      data_length;
    logic [LINK_IDX_W-1:0] release_link;
    logic [SLOT_FLD_W-1:0] release_slot;
  } in_item_t;

  typedef struct packed {
    logic [OUTC_W-1:0]     outcome;
    logic [LINK_IDX_W-1:0] matched_link;
    logic [SLOT_FLD_W-1:0] chosen_slot;
    logic [BUF_W-1:0]      buffer_index;
  } out_item_t;

  // per slot receive record
  typedef struct packed {
    logic [BUF_W-1:0]  buf_idx;
    logic [PORT_W-1:0] peer_port;
    logic [IP_W-1:0]   peer_ip;
    logic [LEN_W-1:0]  length;
  } slot_rec_t;

  // command from the sequencer to the slot table
  typedef struct packed {
    logic                  alloc;
    logic                  release_en;
    logic [LINK_IDX_W-1:0] link;
    logic [SLOT_CMD_W-1:0] slot;
    slot_rec_t             rec;
  } slot_cmd_t;

endpackage
`default_nettype wire

>>> hdl/udp_port_demux_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_port_demux_slot_table: udp destination port demux with slot tables
// matches a datagram header to a link and claims a free receive slot
// ----------------------------------------------------------------------------
// One item is handled at a time. A datagram item walks the link ports one per
// cycle through a single 16-bit equality comparator, and then walks the busy
// flags of the matched link one per cycle through that same comparator. An
// unmatched port skips the busy flag walk, and a release item skips both
// walks and goes straight to the result. The result sits in an output
// register, so a waiting result does not hold up the next item unless it is
// still stalled when the following result is ready. The input side is
// stalled whenever an item is in flight. Link ports reset to zero, all slots
// reset free.
// ----------------------------------------------------------------------------
module udp_port_demux_slot_table #(
  parameter int LINK_COUNT     = udpdm_pkg::LINK_COUNT_DEF,
  parameter int SLOTS_PER_LINK = udpdm_pkg::SLOTS_PER_LINK_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input items
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire udpdm_pkg::in_item_t           in_data,
  // result items
  output logic                               out_valid,
  input  wire                                out_stall,
  output udpdm_pkg::out_item_t               out_data,
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [udpdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [udpdm_pkg::PORT_W-1:0]        cfg_data
);

  localparam int LINK_W = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
  localparam int SLOT_W = (SLOTS_PER_LINK > 1) ? $clog2(SLOTS_PER_LINK) : 1;
  localparam int CNT_W  = (LINK_W > SLOT_W) ? LINK_W : SLOT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [CNT_W-1:0]  LAST_LINK = CNT_W'(LINK_COUNT - 1);
  localparam logic [CNT_W-1:0]  LAST_SLOT = CNT_W'(SLOTS_PER_LINK - 1);
  localparam logic [SLOT_W-1:0] LAST_RING = SLOT_W'(SLOTS_PER_LINK - 1);

  // control state
  logic [1:0]                              state_r, state_nxt;
  logic [CNT_W-1:0]                        cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]                       ring_r, ring_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  logic [udpdm_pkg::PORT_W-1:0]            link_port_r [udpdm_pkg::CFG_REGS];

  // payload
  udpdm_pkg::in_item_t                     item_r;
  udpdm_pkg::out_item_t                    out_data_r, out_data_nxt;
  logic [udpdm_pkg::OUTC_W-1:0]            outcome_r, outcome_nxt;
  logic [udpdm_pkg::LINK_IDX_W-1:0]        link_r, link_nxt;
  logic [SLOT_W-1:0]                       slot_r, slot_nxt;

  // shared comparator
  logic [udpdm_pkg::PORT_W-1:0]            cmp_a;
  logic [udpdm_pkg::PORT_W-1:0]            cmp_b;
  logic                                    cmp_eq;

  logic                                    in_fire;
  logic                                    emit_fire;
  logic                                    rel_ok;
  logic                                    q_busy;
  udpdm_pkg::slot_cmd_t                    cmd;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result register free or being drained this cycle
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // release only touches slots that exist
  assign rel_ok = (int'(item_r.release_link) < LINK_COUNT) &&
                  (int'(item_r.release_slot) < SLOTS_PER_LINK);

  // comparator operands: link port against dest port, or busy flag against zero
  always_comb begin
    if (state_r == S_SCAN) begin
      cmp_a = udpdm_pkg::PORT_W'(q_busy);
      cmp_b = '0;
    end else begin
      cmp_a = link_port_r[udpdm_pkg::LINK_IDX_W'(cnt_r)];
      cmp_b = item_r.dest_port;
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    outcome_nxt = outcome_r;
    link_nxt    = link_r;
    slot_nxt    = slot_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt  = '0;
          link_nxt = '0;
          slot_nxt = '0;
          if (in_data.req_type == udpdm_pkg::REQ_RELEASE) begin
            outcome_nxt = udpdm_pkg::OUT_RELEASED;
            state_nxt   = S_EMIT;
          end else begin
            state_nxt = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        if (cmp_eq) begin
          link_nxt  = udpdm_pkg::LINK_IDX_W'(cnt_r);
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end else if (cnt_r == LAST_LINK) begin
          outcome_nxt = udpdm_pkg::OUT_UNREACHABLE;
          state_nxt   = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        // equal to zero means the slot is free
        if (cmp_eq) begin
          slot_nxt    = SLOT_W'(cnt_r);
          outcome_nxt = udpdm_pkg::OUT_ACCEPTED;
          state_nxt   = S_EMIT;
        end else if (cnt_r == LAST_SLOT) begin
          outcome_nxt = udpdm_pkg::OUT_NO_SLOT;
          state_nxt   = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result assembly
  always_comb begin
    out_data_nxt.outcome      = outcome_r;
    out_data_nxt.matched_link = '0;
    out_data_nxt.chosen_slot  = '0;
    out_data_nxt.buffer_index = '0;
    case (outcome_r)
      udpdm_pkg::OUT_RELEASED: begin
        out_data_nxt.matched_link = item_r.release_link;
        out_data_nxt.chosen_slot  = item_r.release_slot;
      end
      udpdm_pkg::OUT_ACCEPTED: begin
        out_data_nxt.matched_link = link_r;
        out_data_nxt.chosen_slot  = udpdm_pkg::SLOT_FLD_W'(slot_r);
        out_data_nxt.buffer_index = udpdm_pkg::BUF_W'(ring_r);
      end
      udpdm_pkg::OUT_NO_SLOT: begin
        out_data_nxt.matched_link = link_r;
      end
      default: begin
        out_data_nxt.matched_link = '0;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ring index advances on each accepted datagram, wraps at slots per link
  always_comb begin
    ring_nxt = ring_r;
    if (emit_fire && (outcome_r == udpdm_pkg::OUT_ACCEPTED)) begin
      ring_nxt = (ring_r == LAST_RING) ? '0 : ring_r + 1'b1;
    end
  end

  // slot table command, applied as the result is loaded into the result register
  always_comb begin
    cmd.alloc           = emit_fire && (outcome_r == udpdm_pkg::OUT_ACCEPTED);
    cmd.release_en      = emit_fire && (outcome_r == udpdm_pkg::OUT_RELEASED) && rel_ok;
    cmd.link            = (outcome_r == udpdm_pkg::OUT_RELEASED) ?
                          item_r.release_link : link_r;
    cmd.slot            = (outcome_r == udpdm_pkg::OUT_RELEASED) ?
                          udpdm_pkg::SLOT_CMD_W'(item_r.release_slot) :
                          udpdm_pkg::SLOT_CMD_W'(slot_r);
    cmd.rec.buf_idx     = udpdm_pkg::BUF_W'(ring_r);
    cmd.rec.peer_port   = item_r.src_port;
    cmd.rec.peer_ip     = item_r.src_ip;
    cmd.rec.length      = item_r.data_length;
  end

  udpdm_slot_store #(
    .LINK_COUNT     (LINK_COUNT),
    .SLOTS_PER_LINK (SLOTS_PER_LINK)
  ) u_slot_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .q_link (link_r),
    .q_slot (udpdm_pkg::SLOT_CMD_W'(cnt_r)),
    .q_busy (q_busy)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ring_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ring_r      <= ring_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // link port registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < udpdm_pkg::CFG_REGS; i++) begin
        link_port_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      link_port_r[cfg_index] <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    outcome_r <= outcome_nxt;
    link_r    <= link_nxt;
    slot_r    <= slot_nxt;
    if (emit_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/udpdm_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpdm_slot_store: receive slot table
// busy flags per slot with a lookup port, plus the per slot record memory
// ----------------------------------------------------------------------------
module udpdm_slot_store #(
  parameter int LINK_COUNT     = udpdm_pkg::LINK_COUNT_DEF,
  parameter int SLOTS_PER_LINK = udpdm_pkg::SLOTS_PER_LINK_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire udpdm_pkg::slot_cmd_t             cmd,
  input  wire [udpdm_pkg::LINK_IDX_W-1:0]       q_link,
  input  wire [udpdm_pkg::SLOT_CMD_W-1:0]       q_slot,
  output logic                                  q_busy
);

  localparam int SLOT_TOTAL = LINK_COUNT * SLOTS_PER_LINK;
  localparam int ADDR_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

  logic [SLOT_TOTAL-1:0]  busy_r;
  logic [SLOT_TOTAL-1:0]  busy_nxt;
  udpdm_pkg::slot_rec_t   rec_mem [SLOT_TOTAL];
  logic [ADDR_W-1:0]      cmd_addr;
  logic [ADDR_W-1:0]      q_addr;

  // flat address: link * slots_per_link + slot
  assign cmd_addr = ADDR_W'(ADDR_W'(cmd.link) * ADDR_W'(SLOTS_PER_LINK) + ADDR_W'(cmd.slot));
  assign q_addr   = ADDR_W'(ADDR_W'(q_link) * ADDR_W'(SLOTS_PER_LINK) + ADDR_W'(q_slot));

  assign q_busy = busy_r[q_addr];

  always_comb begin
    busy_nxt = busy_r;
    if (cmd.alloc) begin
      busy_nxt[cmd_addr] = 1'b1;
    end else if (cmd.release_en) begin
      busy_nxt[cmd_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // record memory, only written on a slot allocation
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      rec_mem[cmd_addr] <= cmd.rec;
    end
  end

endmodule
`default_nettype wire

>>> bench/udpdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpdm_checker: result checker for the udp port demux
// tracks link ports, slot busy flags and the ring index from the items seen
// on the channels, predicts each result and compares it in order
// ----------------------------------------------------------------------------
module udpdm_checker
  import udpdm_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  wire in_item_t        in_data,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  wire out_item_t       out_data,
  input  wire                  cfg_valid,
  input  wire                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [PORT_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending_results
);

  localparam int LINKS = LINK_COUNT_DEF;
  localparam int SLOTS = SLOTS_PER_LINK_DEF;

  logic [PORT_W-1:0] link_port [CFG_REGS];
  logic [SLOTS-1:0]  slot_busy [LINKS];
  int                ring_pos;
  out_item_t         awaited_results [$];

  // one result per item: updates the slot flags and the ring index
  function automatic out_item_t demux_datagram(input in_item_t it);
    out_item_t r;
    int        lk;
    int        sl;
    r  = '0;
    lk = -1;
    sl = -1;
    if (it.req_type == REQ_RELEASE) begin
      if (it.release_link < LINKS && it.release_slot < SLOTS)
        slot_busy[it.release_link][it.release_slot] = 1'b0;
      r.outcome      = OUT_RELEASED;
      r.matched_link = it.release_link;
      r.chosen_slot  = it.release_slot;
    end else begin
      // lowest matching link wins
      for (int i = LINKS - 1; i >= 0; i--)
        if (link_port[i] == it.dest_port) lk = i;
      if (lk < 0) begin
        r.outcome = OUT_UNREACHABLE;
      end else begin
        r.matched_link = lk[LINK_IDX_W-1:0];
        for (int j = SLOTS - 1; j >= 0; j--)
          if (!slot_busy[lk][j]) sl = j;
        if (sl < 0) begin
          r.outcome = OUT_NO_SLOT;
        end else begin
          slot_busy[lk][sl] = 1'b1;
          r.outcome      = OUT_ACCEPTED;
          r.chosen_slot  = sl[SLOT_FLD_W-1:0];
          r.buffer_index = ring_pos[BUF_W-1:0];
          ring_pos = (ring_pos == SLOTS - 1) ? 0 : ring_pos + 1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < CFG_REGS; i++) link_port[i] = '0;
      for (int i = 0; i < LINKS; i++) slot_busy[i] = '0;
      ring_pos = 0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result item %h", out_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.outcome !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, out_data.outcome);
            fail_count++;
          end
          if (out_data.matched_link !== want.matched_link) begin
            $error("matched_link: expected %0d, actual %0d",
                   want.matched_link, out_data.matched_link);
            fail_count++;
          end
          if (out_data.chosen_slot !== want.chosen_slot) begin
            $error("chosen_slot: expected %0d, actual %0d",
                   want.chosen_slot, out_data.chosen_slot);
            fail_count++;
          end
          if (out_data.buffer_index !== want.buffer_index) begin
            $error("buffer_index: expected %0d, actual %0d",
                   want.buffer_index, out_data.buffer_index);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(demux_datagram(in_data));
      if (cfg_valid && cfg_ready)
        link_port[cfg_index] = cfg_data;
    end
    pending_results = awaited_results.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the udp port demux with slot tables
// drives directed and random datagram and release items under several port
// bindings and idling patterns; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb;
  import udpdm_pkg::*;

  localparam int LINKS      = LINK_COUNT_DEF;
  localparam int SLOTS      = SLOTS_PER_LINK_DEF;
  // worst case cycles for one item inside the block, plus margin
  localparam int ITEM_CYCLES = LINKS + SLOTS + 4;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  // whole run cap in ns, far above the slowest legal run
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PORT_W-1:0]    cfg_data;

  int fails;
  int pending;

  // idling controls, shared by the sender and the receiver process
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  // stimulus copy of the bound ports, only used to aim datagrams at links
  logic [PORT_W-1:0] bound_port [CFG_REGS];

  always #5 clk = ~clk;

  udp_port_demux_slot_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  udpdm_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fails),
    .pending_results (pending)
  );

  // datagram header with random peer fields
  function automatic in_item_t make_arrival(input logic [PORT_W-1:0] dport);
    in_item_t it;
    it              = '0;
    it.req_type     = REQ_ARRIVAL;
    it.dest_port    = dport;
    it.src_port     = PORT_W'($urandom_range(16'hFFFF));
    it.src_ip       = $urandom;
    it.data_length  = LEN_W'($urandom_range(16'hFFFF));
    // ignored on an arrival, but toggled anyway
    it.release_link = LINK_IDX_W'($urandom_range(LINKS - 1));
    it.release_slot = SLOT_FLD_W'($urandom_range(SLOTS - 1));
    return it;
  endfunction

  // slot free request, the header fields carry junk
  function automatic in_item_t make_freeing(input int lk, input int sl);
    in_item_t it;
    it              = make_arrival(PORT_W'($urandom_range(16'hFFFF)));
    it.req_type     = REQ_RELEASE;
    it.release_link = lk[LINK_IDX_W-1:0];
    it.release_slot = sl[SLOT_FLD_W-1:0];
    return it;
  endfunction

  // random traffic: datagrams aimed at a bound port most often, then frees,
  // then stray ports
  function automatic in_item_t pick_traffic();
    int roll;
    roll = int'($urandom_range(99));
    if (roll < 40)
      return make_freeing(int'($urandom_range(LINKS - 1)), int'($urandom_range(SLOTS - 1)));
    else if (roll < 85)
      return make_arrival(bound_port[CFG_IDX_W'($urandom_range(CFG_REGS - 1))]);
    else
      return make_arrival(PORT_W'($urandom_range(16'hFFFF)));
  endfunction

  // called just after a falling edge; returns just after the falling edge
  // that follows acceptance, leaving in_valid high for a back-to-back item
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // waits until every result has come out; in_valid must already be low
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (ITEM_CYCLES) @(negedge clk);
  endtask

  // writes all four link ports in order, valid stays up between writes
  task automatic program_ports(input logic [PORT_W-1:0] p0, input logic [PORT_W-1:0] p1,
                               input logic [PORT_W-1:0] p2, input logic [PORT_W-1:0] p3);
    logic [PORT_W-1:0] vals [CFG_REGS];
    vals = '{p0, p1, p2, p3};
    for (int i = 0; i < CFG_REGS; i++) begin
      cfg_index = i[CFG_IDX_W-1:0];
      cfg_data  = vals[i];
      cfg_valid = 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      bound_port[i] = vals[i];
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off when asked for one
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run cap
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_item_t it;
    int       waited;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < CFG_REGS; i++) bound_port[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed part ---
    // reset binding: every link on port 0, so port 0 lands on link 0
    send_item(make_arrival(16'h0000));
    send_item(make_arrival(16'hFFFF));                 // unreachable
    send_item(make_freeing(0, 0));
    in_valid = 1'b0;
    wait_idle();

    // max port on link 0, duplicate binding on links 1 and 2, zero on link 3
    program_ports(16'hFFFF, 16'h0035, 16'h0035, 16'h0000);
    // fill link 0, the ring index wraps on the way
    for (int i = 0; i < SLOTS; i++) send_item(make_arrival(16'hFFFF));
    send_item(make_arrival(16'hFFFF));                 // no free slot
    send_item(make_freeing(0, 5));
    // all-ones header fields, then all-zero ones
    it             = make_arrival(16'hFFFF);
    it.src_port    = 16'hFFFF;
    it.src_ip      = 32'hFFFF_FFFF;
    it.data_length = 16'hFFFF;
    send_item(it);                                     // reuses slot 5
    send_freeing_extremes: begin
      send_item(make_freeing(LINKS - 1, SLOTS - 1));   // free slot, no change
    end
    send_item(make_arrival(16'h0035));                 // lowest duplicate wins
    it             = make_arrival(16'h0000);
    it.src_port    = '0;
    it.src_ip      = '0;
    it.data_length = '0;
    send_item(it);                                     // link 3
    send_item(make_arrival(16'h1234));                 // unreachable
    send_item(make_freeing(1, 0));
    send_item(make_freeing(0, 0));
    in_valid = 1'b0;

    // --- random part, one binding and idling pattern per phase ---
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          program_ports(16'h0000, 16'hFFFF, PORT_W'($urandom_range(16'hFFFF)),
                        PORT_W'($urandom_range(16'hFFFF)));
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          // everything on one port: only link 0 ever matches, it fills up
          program_ports(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          send_gap_pct   = 50;
          recv_stall_pct = 0;
        end
        2: begin
          program_ports(PORT_W'($urandom_range(16'hFFFF)), PORT_W'($urandom_range(16'hFFFF)),
                        PORT_W'($urandom_range(16'hFFFF)), PORT_W'($urandom_range(16'hFFFF)));
          send_gap_pct   = 0;
          recv_stall_pct = 50;
          // long hold-off while the sender keeps offering items
          hold_cycles    = HOLD_CYCLES;
        end
        3: begin
          program_ports(16'd7, 16'd7, 16'd8, PORT_W'($urandom_range(16'hFFFF)));
          send_gap_pct   = 7;
          recv_stall_pct = 7;
        end
        default: begin
          program_ports(PORT_W'($urandom_range(16'hFFFF)), 16'h0000,
                        PORT_W'($urandom_range(16'hFFFF)), 16'hFFFF);
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(pick_traffic());
      in_valid = 1'b0;
    end

    // --- drain and verdict ---
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (ITEM_CYCLES) @(negedge clk);
    if (pending != 0) $error("%0d result items never arrived", pending);
    if (fails == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
